@@ hdl/assert_macros.svh @@
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition c in the same cycle.
`define ASSERT_IMP(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
		else $error("same-cycle implication failed");

// Condition a implies condition c in the next cycle.
`define ASSERT_NXT(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
		else $error("next-cycle implication failed");

`endif

@@ hdl/cbpr_pkg.sv @@
// Types, constants and the address fold shared by the bus register unit.
package cbpr_pkg;

	localparam int MAIN_DEPTH   = 65536;
	localparam int MAIN_AW      = 16;
	localparam int SPRITE_DEPTH = 256;
	localparam int SPRITE_AW    = 8;

	// Request type codes
	localparam logic [2:0] RT_CPU_RD   = 3'd0;
	localparam logic [2:0] RT_CPU_WR   = 3'd1;
	localparam logic [2:0] RT_PAD_LOAD = 3'd2;
	localparam logic [2:0] RT_VRAM_RD  = 3'd3;
	localparam logic [2:0] RT_OAM_RD   = 3'd4;
	localparam logic [2:0] RT_POLL     = 3'd5;

	// Register addresses after folding
	localparam logic [15:0] REG_CTRL      = 16'h2000;
	localparam logic [15:0] REG_STATUS    = 16'h2002;
	localparam logic [15:0] REG_OAM_ADDR  = 16'h2003;
	localparam logic [15:0] REG_OAM_DATA  = 16'h2004;
	localparam logic [15:0] REG_VRAM_ADDR = 16'h2006;
	localparam logic [15:0] REG_VRAM_DATA = 16'h2007;
	localparam logic [15:0] REG_DMA       = 16'h4014;
	localparam logic [15:0] REG_PAD       = 16'h4016;
	localparam logic [7:0]  PAL_PAGE      = 8'h3F;
	localparam int          INC_BIT       = 2;
	localparam logic [15:0] STEP_WIDE     = 16'd32;
	localparam logic [15:0] STEP_ONE      = 16'd1;

	// Classified operation carried from front to back
	typedef enum logic [3:0] {
		OP_NOP,
		OP_RD_STATUS,
		OP_RD_PAD,
		OP_RD_VDATA,
		OP_RD_MAIN,
		OP_WR_OAMADDR,
		OP_WR_OAMDATA,
		OP_WR_VADDR,
		OP_WR_VDATA,
		OP_WR_DMA,
		OP_WR_MAIN,
		OP_PAD_LOAD,
		OP_VRAM_RD,
		OP_OAM_RD,
		OP_POLL
	} op_t;

	typedef struct packed {
		logic        valid;
		op_t         op;
		logic [15:0] addr;
		logic [15:0] data;
	} f2b_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} b2f_t;

	// CPU bus mirroring of RAM and of the picture registers
	function automatic logic [15:0] fold_addr(input logic [15:0] a);
		logic [15:0] r;
		r = a;
		if (a >= 16'h0800 && a <= 16'h1FFF)
			r = a & 16'h07FF;
		else if (a >= 16'h2008 && a <= 16'h3FFF)
			r = 16'h2000 + (a & 16'h0007);
		return r;
	endfunction

endpackage

@@ hdl/cbpr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cbpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

@@ hdl/cbpr_front.sv @@
// Front part: accepts requests, folds and classifies them, queues two entries.
module cbpr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [2:0]        req_type,
	input  logic [15:0]       address,
	input  logic [15:0]       write_data,
	input  cbpr_pkg::b2f_t    b2f,
	output cbpr_pkg::f2b_t    f2b
);

	cbpr_pkg::f2b_t ent_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	cbpr_pkg::op_t  op;
	logic [15:0]    fa;
	logic [15:0]    ea;
	logic           push;

	// Classify the incoming request
	always_comb begin
		fa = cbpr_pkg::fold_addr(address);
		ea = fa;
		op = cbpr_pkg::OP_NOP;
		unique case (req_type)
			cbpr_pkg::RT_CPU_RD: begin
				if (fa == cbpr_pkg::REG_STATUS)
					op = cbpr_pkg::OP_RD_STATUS;
				else if (fa == cbpr_pkg::REG_PAD)
					op = cbpr_pkg::OP_RD_PAD;
				else if (fa == cbpr_pkg::REG_VRAM_DATA)
					op = cbpr_pkg::OP_RD_VDATA;
				else
					op = cbpr_pkg::OP_RD_MAIN;
			end
			cbpr_pkg::RT_CPU_WR: begin
				if (fa == cbpr_pkg::REG_OAM_ADDR)
					op = cbpr_pkg::OP_WR_OAMADDR;
				else if (fa == cbpr_pkg::REG_OAM_DATA)
					op = cbpr_pkg::OP_WR_OAMDATA;
				else if (fa == cbpr_pkg::REG_VRAM_ADDR)
					op = cbpr_pkg::OP_WR_VADDR;
				else if (fa == cbpr_pkg::REG_VRAM_DATA)
					op = cbpr_pkg::OP_WR_VDATA;
				else if (fa == cbpr_pkg::REG_DMA)
					op = cbpr_pkg::OP_WR_DMA;
				else if (fa == cbpr_pkg::REG_PAD)
					op = cbpr_pkg::OP_NOP;
				else
					op = cbpr_pkg::OP_WR_MAIN;
			end
			cbpr_pkg::RT_PAD_LOAD: op = cbpr_pkg::OP_PAD_LOAD;
			cbpr_pkg::RT_VRAM_RD: begin
				op = cbpr_pkg::OP_VRAM_RD;
				ea = address;
			end
			cbpr_pkg::RT_OAM_RD: begin
				op = cbpr_pkg::OP_OAM_RD;
				ea = address;
			end
			cbpr_pkg::RT_POLL: op = cbpr_pkg::OP_POLL;
			default: op = cbpr_pkg::OP_NOP;
		endcase
	end

	assign req_stall = (cnt_q == 2'd2) || b2f.clearing;
	assign push      = req_valid && !req_stall;

	// Two-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (b2f.pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, b2f.pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= '{valid: 1'b1, op: op, addr: ea, data: write_data};
	end

	always_comb begin
		f2b       = ent_q[rp_q];
		f2b.valid = (cnt_q != 2'd0);
	end

endmodule

@@ hdl/cbpr_back.sv @@
// Back part: executes queued operations against the memories and registers.
module cbpr_back #(
	parameter int VIDEO_DEPTH = 16384
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cbpr_pkg::f2b_t f2b,
	output cbpr_pkg::b2f_t b2f,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output logic [7:0]     read_data,
	output logic           palette_changed
);

	localparam int VW = $clog2(VIDEO_DEPTH);

	typedef enum logic [6:0] {
		S_CLEAR  = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_EXEC   = 7'b0000100,
		S_WR2    = 7'b0001000,
		S_DMA_RD = 7'b0010000,
		S_DMA_WR = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	state_t         state_q, state_d;
	logic [15:0]    clr_q;
	cbpr_pkg::op_t  op_q;
	logic [15:0]    addr_q, data_q;
	logic [15:0]    vptr_q, vptr_d;
	logic [7:0]     rbuf_q, rbuf_d;
	logic [7:0]     sptr_q, sptr_d;
	logic           pflag_q, pflag_d;
	logic [7:0]     pad_q, pad_d;
	logic           inc_q, inc_d;
	logic [7:0]     pg_q, idx_q;
	logic [15:0]    da_q;
	logic [7:0]     rd_q, rd_d;
	logic           pc_q, pc_d;
	logic           slot_free;
	logic [15:0]    step;
	logic [15:0]    dma_a;
	logic [7:0]     dval;

	logic                 m_we, m_re;
	logic [15:0]          m_wa, m_ra;
	logic [7:0]           m_wd, m_rd;
	logic                 v_we, v_re;
	logic [VW-1:0]        v_wa, v_ra;
	logic [7:0]           v_wd, v_rd;
	logic                 s_we, s_re;
	logic [7:0]           s_wa, s_ra, s_wd, s_rd;

	// Index reduction into video RAM; the value is below four times the depth
	function automatic logic [VW-1:0] vmod(input logic [15:0] x);
		logic [16:0] r;
		r = {1'b0, x};
		for (int k = 0; k < 3; k++) begin
			if (r >= 17'(VIDEO_DEPTH))
				r = r - 17'(VIDEO_DEPTH);
		end
		return r[VW-1:0];
	endfunction

	cbpr_ram #(.WIDTH(8), .DEPTH(cbpr_pkg::MAIN_DEPTH)) u_main (
		.clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd),
		.re(m_re), .raddr(m_ra), .rdata(m_rd)
	);
	cbpr_ram #(.WIDTH(8), .DEPTH(VIDEO_DEPTH)) u_video (
		.clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd),
		.re(v_re), .raddr(v_ra), .rdata(v_rd)
	);
	cbpr_ram #(.WIDTH(8), .DEPTH(cbpr_pkg::SPRITE_DEPTH)) u_sprite (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd),
		.re(s_re), .raddr(s_ra), .rdata(s_rd)
	);

	assign slot_free    = !rsp_valid || !rsp_stall;
	assign step         = inc_q ? cbpr_pkg::STEP_WIDE : cbpr_pkg::STEP_ONE;
	assign dma_a        = cbpr_pkg::fold_addr({pg_q, idx_q});
	assign b2f.clearing = (state_q == S_CLEAR);
	assign b2f.pop      = (state_q == S_IDLE) && f2b.valid;

	// Sequencer and memory control
	always_comb begin
		state_d = state_q;
		vptr_d  = vptr_q;
		rbuf_d  = rbuf_q;
		sptr_d  = sptr_q;
		pflag_d = pflag_q;
		pad_d   = pad_q;
		inc_d   = inc_q;
		rd_d    = rd_q;
		pc_d    = pc_q;
		dval    = m_rd;
		m_we = 1'b0; m_wa = addr_q;        m_wd = data_q[7:0];
		m_re = 1'b0; m_ra = f2b.addr;
		v_we = 1'b0; v_wa = vmod(vptr_q);  v_wd = data_q[7:0];
		v_re = 1'b0; v_ra = vmod(vptr_q);
		s_we = 1'b0; s_wa = sptr_q;        s_wd = data_q[7:0];
		s_re = 1'b0; s_ra = f2b.addr[7:0];
		unique case (state_q)
			S_CLEAR: begin
				m_we = 1'b1; m_wa = clr_q; m_wd = '0;
				v_we = ({1'b0, clr_q} < 17'(VIDEO_DEPTH));
				v_wa = clr_q[VW-1:0]; v_wd = '0;
				s_we = (clr_q < 16'(cbpr_pkg::SPRITE_DEPTH));
				s_wa = clr_q[7:0]; s_wd = '0;
				if (clr_q == 16'hFFFF)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (f2b.valid) begin
					rd_d = '0;
					pc_d = 1'b0;
					m_re = (f2b.op == cbpr_pkg::OP_RD_STATUS) ||
					       (f2b.op == cbpr_pkg::OP_RD_MAIN);
					v_re = (f2b.op == cbpr_pkg::OP_RD_VDATA) ||
					       (f2b.op == cbpr_pkg::OP_VRAM_RD);
					if (f2b.op == cbpr_pkg::OP_VRAM_RD)
						v_ra = vmod(f2b.addr);
					s_re = (f2b.op == cbpr_pkg::OP_OAM_RD);
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_OUT;
				case (op_q)
					cbpr_pkg::OP_RD_STATUS: begin
						vptr_d = '0;
						rd_d   = m_rd;
					end
					cbpr_pkg::OP_RD_PAD: begin
						rd_d  = {7'd0, pad_q[0]};
						pad_d = {1'b0, pad_q[7:1]};
					end
					cbpr_pkg::OP_RD_VDATA: begin
						rd_d   = rbuf_q;
						rbuf_d = v_rd;
						vptr_d = vptr_q + step;
					end
					cbpr_pkg::OP_RD_MAIN: rd_d = m_rd;
					cbpr_pkg::OP_WR_OAMADDR: sptr_d = data_q[7:0];
					cbpr_pkg::OP_WR_OAMDATA: begin
						s_we   = 1'b1;
						sptr_d = sptr_q + 8'd1;
					end
					cbpr_pkg::OP_WR_VADDR: begin
						if (vptr_q == 16'd0)
							vptr_d = {8'd0, data_q[7:0]};
						else
							vptr_d = {vptr_q[7:0], 8'd0} + {8'd0, data_q[7:0]};
					end
					cbpr_pkg::OP_WR_VDATA: begin
						v_we = 1'b1;
						if (vptr_q[15:8] == cbpr_pkg::PAL_PAGE)
							pflag_d = 1'b1;
						vptr_d = vptr_q + step;
					end
					cbpr_pkg::OP_WR_DMA: state_d = S_DMA_RD;
					cbpr_pkg::OP_WR_MAIN: begin
						m_we = 1'b1;
						if (data_q[15:8] != 8'd0) begin
							m_wd    = data_q[15:8];
							state_d = S_WR2;
						end
						if (addr_q == cbpr_pkg::REG_CTRL)
							inc_d = m_wd[cbpr_pkg::INC_BIT];
					end
					cbpr_pkg::OP_PAD_LOAD: pad_d = data_q[7:0];
					cbpr_pkg::OP_VRAM_RD: rd_d = v_rd;
					cbpr_pkg::OP_OAM_RD: rd_d = s_rd;
					cbpr_pkg::OP_POLL: begin
						pc_d    = pflag_q;
						pflag_d = 1'b0;
					end
					default: ;
				endcase
			end
			S_WR2: begin
				// second byte of a two-byte store, no refold
				m_we = 1'b1;
				m_wa = addr_q + 16'd1;
				if (m_wa == cbpr_pkg::REG_PAD)
					pad_d = data_q[7:0];
				if (m_wa == cbpr_pkg::REG_CTRL)
					inc_d = data_q[cbpr_pkg::INC_BIT];
				state_d = S_OUT;
			end
			S_DMA_RD: begin
				m_re = 1'b1;
				m_ra = dma_a;
				v_re = 1'b1;
				state_d = S_DMA_WR;
			end
			S_DMA_WR: begin
				// full bus read with its side effects, copied to sprite RAM
				if (da_q == cbpr_pkg::REG_STATUS) begin
					vptr_d = '0;
				end else if (da_q == cbpr_pkg::REG_PAD) begin
					dval  = {7'd0, pad_q[0]};
					pad_d = {1'b0, pad_q[7:1]};
				end else if (da_q == cbpr_pkg::REG_VRAM_DATA) begin
					dval   = rbuf_q;
					rbuf_d = v_rd;
					vptr_d = vptr_q + step;
				end
				s_we = 1'b1;
				s_wa = idx_q;
				s_wd = dval;
				state_d = (idx_q == 8'hFF) ? S_OUT : S_DMA_RD;
			end
			S_OUT: begin
				if (slot_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			vptr_q    <= '0;
			rbuf_q    <= '0;
			sptr_q    <= '0;
			pflag_q   <= 1'b0;
			pad_q     <= '0;
			inc_q     <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + 16'd1;
			vptr_q  <= vptr_d;
			rbuf_q  <= rbuf_d;
			sptr_q  <= sptr_d;
			pflag_q <= pflag_d;
			pad_q   <= pad_d;
			inc_q   <= inc_d;
			if (state_q == S_OUT && slot_free)
				rsp_valid <= 1'b1;
			else if (!rsp_stall)
				rsp_valid <= 1'b0;
		end
	end

	// Operation payload, DMA walk and result
	always_ff @(posedge clk) begin
		rd_q <= rd_d;
		pc_q <= pc_d;
		if (b2f.pop) begin
			op_q   <= f2b.op;
			addr_q <= f2b.addr;
			data_q <= f2b.data;
		end
		if (state_q == S_EXEC) begin
			pg_q  <= data_q[7:0];
			idx_q <= sptr_q;
		end
		if (state_q == S_DMA_RD)
			da_q <= dma_a;
		if (state_q == S_DMA_WR)
			idx_q <= idx_q + 8'd1;
		if (state_q == S_OUT && slot_free) begin
			read_data       <= rd_q;
			palette_changed <= pc_q;
		end
	end

endmodule

@@ hdl/console_cpu_bus_ppu_registers_unit.sv @@
// Top level of the CPU bus and picture-unit register block.
// Usage:
//   Request channel (req_valid/req_stall): req_type, address, write_data.
//   Response channel (rsp_valid/rsp_stall): read_data, palette_changed.
//   Every request gives exactly one response, in request order.
//   A request is queued by the front part (two entries) and executed by the
//   back sequencer: pop, execute, deliver. A two-byte store adds a second
//   write step, and an OAM DMA write adds a read step and a write step for
//   each byte from the sprite pointer to 255, the read step being needed for
//   the registered read of main RAM. The back part takes the next request
//   only after its last response is in the output register; the queue holds further requests meanwhile.
//   After reset a clearing pass zeroes main, video and sprite RAM, one entry
//   per cycle up to the last main RAM address; req_stall is high until it ends.
//   The response sits in an output register; while rsp_stall is high the
//   back part waits with its next result and the queue keeps taking requests
//   until it holds two.
`include "assert_macros.svh"

module console_cpu_bus_ppu_registers_unit #(
	parameter int VIDEO_DEPTH = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [15:0] address,
	input  logic [15:0] write_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [7:0]  read_data,
	output logic        palette_changed
);

	cbpr_pkg::f2b_t f2b;
	cbpr_pkg::b2f_t b2f;

	cbpr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.req_type(req_type), .address(address), .write_data(write_data),
		.b2f(b2f), .f2b(f2b)
	);

	cbpr_back #(.VIDEO_DEPTH(VIDEO_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.f2b(f2b), .b2f(b2f),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.read_data(read_data), .palette_changed(palette_changed)
	);

	// Checks
	`ASSERT_IMP(a_clear_blocks, clk, arst_n, b2f.clearing, req_stall)
	`ASSERT_IMP(a_pop_has_entry, clk, arst_n, b2f.pop, f2b.valid)
	`ASSERT_NXT(a_clear_once, clk, arst_n, !b2f.clearing, !b2f.clearing)

endmodule

@@ tb/cbpr_bus_checker.sv @@
// Bus checker: predicts each response from the request transfers and compares it.
module cbpr_bus_checker #(
	parameter int VIDEO_DEPTH = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [15:0] address,
	input  logic [15:0] write_data,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [7:0]  read_data,
	input  logic        palette_changed,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import cbpr_pkg::*;

	typedef struct packed {
		logic [7:0] rd;
		logic       pc;
	} bus_rsp_t;

	// Shadow copy of the bus state
	logic [7:0]  main_mem [MAIN_DEPTH];
	logic [7:0]  video_mem [VIDEO_DEPTH];
	logic [7:0]  sprite_mem [SPRITE_DEPTH];
	logic [15:0] vptr;
	logic [7:0]  rbuf;
	logic [7:0]  sptr;
	logic        pal_flag;
	bus_rsp_t    rsp_q[$];

	initial begin
		foreach (main_mem[i]) main_mem[i] = '0;
		foreach (video_mem[i]) video_mem[i] = '0;
		foreach (sprite_mem[i]) sprite_mem[i] = '0;
		vptr = '0;
		rbuf = '0;
		sptr = '0;
		pal_flag = 1'b0;
		fail_count = 0;
		pending = 0;
	end

	function automatic logic [15:0] mirror(input logic [15:0] a);
		if (a >= 16'h0800 && a <= 16'h1FFF)
			return a & 16'h07FF;
		if (a >= 16'h2008 && a <= 16'h3FFF)
			return 16'h2000 | (a & 16'h0007);
		return a;
	endfunction

	function automatic void step_vptr();
		vptr = vptr + (main_mem[REG_CTRL][INC_BIT] ? STEP_WIDE : STEP_ONE);
	endfunction

	// CPU read with its side effects
	function automatic logic [7:0] cpu_read(input logic [15:0] raw);
		logic [15:0] a;
		logic [7:0]  v;
		a = mirror(raw);
		if (a == REG_STATUS) begin
			vptr = '0;
			return main_mem[a];
		end
		if (a == REG_PAD) begin
			v = main_mem[REG_PAD];
			main_mem[REG_PAD] = v >> 1;
			return {7'd0, v[0]};
		end
		if (a == REG_VRAM_DATA) begin
			v = rbuf;
			rbuf = video_mem[vptr % VIDEO_DEPTH];
			step_vptr();
			return v;
		end
		return main_mem[a];
	endfunction

	// CPU write with its side effects
	function automatic void cpu_write(input logic [15:0] raw, input logic [15:0] d);
		logic [15:0] a;
		logic [15:0] src;
		a = mirror(raw);
		case (a)
			REG_OAM_ADDR: sptr = d[7:0];
			REG_OAM_DATA: begin
				sprite_mem[sptr] = d[7:0];
				sptr = sptr + 8'd1;
			end
			REG_VRAM_ADDR: begin
				if (vptr == 16'd0)
					vptr = {8'd0, d[7:0]};
				else
					vptr = {vptr[7:0], 8'd0} + {8'd0, d[7:0]};
			end
			REG_VRAM_DATA: begin
				video_mem[vptr % VIDEO_DEPTH] = d[7:0];
				if (vptr[15:8] == PAL_PAGE)
					pal_flag = 1'b1;
				step_vptr();
			end
			REG_DMA: begin
				for (int i = sptr; i < SPRITE_DEPTH; i++) begin
					src = {d[7:0], 8'd0} + 16'(i);
					sprite_mem[i] = cpu_read(src);
				end
			end
			REG_PAD: ;
			default: begin
				if (d[15:8] != 8'd0) begin
					main_mem[a] = d[15:8];
					main_mem[a + 16'd1] = d[7:0];
				end else begin
					main_mem[a] = d[7:0];
				end
			end
		endcase
	endfunction

	function automatic bus_rsp_t predict_rsp(input logic [2:0] t, input logic [15:0] a,
		input logic [15:0] d);
		bus_rsp_t r;
		r = '0;
		case (t)
			RT_CPU_RD: r.rd = cpu_read(a);
			RT_CPU_WR: cpu_write(a, d);
			RT_PAD_LOAD: main_mem[REG_PAD] = d[7:0];
			RT_VRAM_RD: r.rd = video_mem[a % VIDEO_DEPTH];
			RT_OAM_RD: r.rd = sprite_mem[a[7:0]];
			RT_POLL: begin
				r.pc = pal_flag;
				pal_flag = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Compare each response transfer, then predict for the request transfer
	always @(posedge clk) begin
		bus_rsp_t e;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (rsp_q.size() == 0) begin
					report("unexpected response", read_data, 0);
				end else begin
					e = rsp_q.pop_front();
					if (read_data !== e.rd)
						report("read_data", read_data, e.rd);
					if (palette_changed !== e.pc)
						report("palette_changed", palette_changed, e.pc);
				end
			end
			if (req_valid && !req_stall)
				rsp_q.push_back(predict_rsp(req_type, address, write_data));
			pending = rsp_q.size();
		end
	end
endmodule

@@ tb/console_cpu_bus_ppu_registers_unit_tb.sv @@
// Top of the bus register testbench: clock, reset, stimulus and verdict.
module console_cpu_bus_ppu_registers_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cbpr_pkg::*;

	localparam int IDLE_LIMIT = 200000;
	localparam int NUM_ITEMS  = 1200;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [2:0]  req_type;
	logic [15:0] address;
	logic [15:0] write_data;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [7:0]  read_data;
	logic        palette_changed;
	int          fail_count;
	int          pending;
	int          sent;
	int          idle_cycles;
	int          stall_left;
	bit          rsp_quiet;
	bit          tx_quiet;

	console_cpu_bus_ppu_registers_unit DUT (.*);

	cbpr_bus_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Response-side stall: runs of random length, most short
	initial begin
		rsp_stall = 1'b0;
		stall_left = 0;
	end
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (rsp_quiet) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= ($urandom_range(0, 2) == 0);
			stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
				: $urandom_range(0, 3);
		end
	end

	// Watchdog on cycles with no transfer on either channel
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send(input logic [2:0] t, input logic [15:0] a, input logic [15:0] d);
		int gap;
		gap = 0;
		if (!tx_quiet && $urandom_range(0, 3) == 0)
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= t;
		address <= a;
		write_data <= d;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent++;
	endtask

	// Address mix biased toward the register window
	function automatic logic [15:0] pick_addr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return REG_CTRL + 16'($urandom_range(0, 7));
		if (r < 35) return 16'h2000 + 16'($urandom_range(0, 16'h1FFF));
		if (r < 43) return REG_PAD;
		if (r < 45) return REG_DMA;
		if (r < 75) return 16'($urandom_range(0, 16'h1FFF));
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_data();
		if ($urandom_range(0, 3) == 0) return 16'($urandom);
		return {8'd0, 8'($urandom)};
	endfunction

	initial begin
		int kind;
		int n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = RT_CPU_RD;
		address = '0;
		write_data = '0;
		sent = 0;
		rsp_quiet = 1'b1;
		tx_quiet = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, each request type and the register cases
		send(RT_CPU_WR, 16'hFFFF, 16'hA55A);
		send(RT_CPU_RD, 16'hFFFF, 16'h0000);
		send(RT_CPU_RD, 16'h0000, 16'hFFFF);
		send(RT_CPU_WR, 16'h0800, 16'h0042);
		send(RT_CPU_RD, 16'h1FFF, 16'h0000);
		send(RT_CPU_WR, 16'h3FFF, 16'h00FF);
		send(RT_PAD_LOAD, 16'h0000, 16'h00A5);
		send(RT_CPU_RD, REG_PAD, 16'h0000);
		send(RT_CPU_WR, REG_PAD, 16'h0001);
		send(RT_CPU_WR, REG_VRAM_ADDR, 16'h003F);
		send(RT_CPU_WR, REG_VRAM_ADDR, 16'h0000);
		send(RT_CPU_WR, REG_VRAM_DATA, 16'h0017);
		send(RT_POLL, 16'h0000, 16'h0000);
		send(RT_POLL, 16'h0000, 16'h0000);
		send(RT_CPU_RD, REG_STATUS, 16'h0000);
		send(RT_CPU_WR, REG_CTRL, 16'h0004);
		send(RT_CPU_WR, REG_VRAM_DATA, 16'h0033);
		send(RT_CPU_RD, REG_VRAM_DATA, 16'h0000);
		send(RT_CPU_RD, REG_VRAM_DATA, 16'h0000);
		send(RT_CPU_WR, REG_OAM_ADDR, 16'h00F0);
		send(RT_CPU_WR, REG_OAM_DATA, 16'hFF99);
		send(RT_CPU_WR, REG_DMA, 16'h0000);
		send(RT_OAM_RD, 16'hFFF1, 16'h0000);
		send(RT_VRAM_RD, 16'hFFFF, 16'h0000);
		send(3'd6, 16'h1234, 16'h5678);
		send(3'd7, 16'hFFFF, 16'hFFFF);

		// Random part: well-formed register sequences plus noise
		rsp_quiet = 1'b0;
		tx_quiet = 1'b0;
		while (sent < NUM_ITEMS) begin
			if ((sent / 300) % 2 == 1 && sent % 300 < 60) begin
				rsp_quiet = 1'b1;
				tx_quiet = 1'b1;
			end else begin
				rsp_quiet = 1'b0;
				tx_quiet = 1'b0;
			end
			if (sent >= 600 && sent < 610) begin
				// hold off until the response queue drains
				req_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1: begin
					// VRAM pointer setup, then data accesses
					if ($urandom_range(0, 1)) send(RT_CPU_RD, REG_STATUS, 16'h0000);
					send(RT_CPU_WR, REG_VRAM_ADDR,
						{8'($urandom), 2'b00, 6'($urandom_range(0, 63))});
					send(RT_CPU_WR, REG_VRAM_ADDR, pick_data());
					n = $urandom_range(1, 6);
					repeat (n)
						send($urandom_range(0, 1) ? RT_CPU_WR : RT_CPU_RD,
							REG_VRAM_DATA, pick_data());
					if ($urandom_range(0, 2) == 0) send(RT_POLL, pick_addr(), pick_data());
					if ($urandom_range(0, 1)) send(RT_VRAM_RD, 16'($urandom), pick_data());
				end
				2: begin
					// sprite pointer and data
					send(RT_CPU_WR, REG_OAM_ADDR, pick_data());
					n = $urandom_range(1, 4);
					repeat (n) send(RT_CPU_WR, REG_OAM_DATA, pick_data());
					send(RT_OAM_RD, 16'($urandom), pick_data());
				end
				3: begin
					// controller load and shift out
					send(RT_PAD_LOAD, 16'($urandom), pick_data());
					n = $urandom_range(1, 8);
					repeat (n) send(RT_CPU_RD, REG_PAD, pick_data());
				end
				4: send(RT_CPU_WR, REG_CTRL, pick_data());
				default: begin
					n = $urandom_range(0, 99);
					send((n < 40) ? RT_CPU_RD : (n < 80) ? RT_CPU_WR : 3'($urandom),
						pick_addr(), pick_data());
				end
			endcase
		end

		// Drain and give the verdict
		req_valid <= 1'b0;
		rsp_quiet = 1'b1;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
